// ===== src/pfba_pkg.sv =====
// shared constants and types for the page frame bitmap allocator
package pfba_pkg;

    // bitmap geometry
    localparam int MAX_FRAMES   = 65536;
    localparam int WORD_BITS    = 32;
    localparam int BITMAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W      = $clog2(BITMAP_WORDS);
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int FRAME_IDX_W  = WADDR_W + BIT_W;
    localparam int COUNT_W      = FRAME_IDX_W + 1;

    // address and register widths
    localparam int FRAME_SHIFT  = 12;
    localparam int ADDR_W       = 32;
    localparam int INDEX_W      = 16;
    localparam int CFG_COUNT_W  = 17;
    localparam int CFG_DATA_W   = 32;

    // request kinds
    typedef enum logic [1:0] {
        REQ_FIND     = 2'd0,
        REQ_SET_IDX  = 2'd1,
        REQ_READ_IDX = 2'd2,
        REQ_SET_ADDR = 2'd3
    } req_type_t;

    // configuration register indexes
    typedef enum logic {
        CFG_FRAME_BASE  = 1'b0,
        CFG_FRAME_COUNT = 1'b1
    } cfg_index_t;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_ACC_RD,
        ST_ACC_WR
    } pfba_state_t;

endpackage

// ===== src/page_frame_bitmap_allocator.sv =====
// page frame bitmap allocator: one bit per 4 KiB frame held in a two-port bitmap memory
//
// Requests enter on start/busy: a transaction is taken at a clock edge with start high and
// busy low. Every transaction gives exactly one result, shown for one cycle with done high;
// the receiver cannot hold results off, so results are never delayed by the output side.
// Configuration (frame_base, frame_count) is written through cfg_write/cfg_index/cfg_data
// with no wait; the user must write it only while idle: the block does not enforce this.
// After reset a clearing pass writes one bitmap word per cycle, all 2048 words, while busy
// stays high; configuration writes are taken during the pass.
// Every transaction first passes a decode step. An out-of-range request, or a find with a
// zero frame count, ends there. Set by index or address and read by index then read the
// word and go to a write back step; a read returns the bit there and writes nothing. A
// find free checks the bitmap word by word, up to 2048 words, until a free frame shows.
// The find search reads one 32-frame bitmap word at a time through the memory's
// single read port, so its time grows with how full the low part of the bitmap is.
// busy drops in the cycle that done is shown, so a new request can start then.
module page_frame_bitmap_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          start,
    output logic                          busy,
    input  pfba_pkg::req_type_t           req_type,
    input  logic [pfba_pkg::INDEX_W-1:0]  frame_index,
    input  logic [pfba_pkg::ADDR_W-1:0]   frame_address,
    input  logic                          frame_state,
    // result channel
    output logic                          done,
    output logic                          found,
    output logic [pfba_pkg::ADDR_W-1:0]   free_address,
    output logic                          bit_value,
    output logic                          in_range,
    // configuration port
    input  logic                          cfg_write,
    input  pfba_pkg::cfg_index_t          cfg_index,
    input  logic [pfba_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pfba_pkg::*;

    // bitmap memory
    logic [WORD_BITS-1:0] bitmap_mem [BITMAP_WORDS];
    logic [WORD_BITS-1:0] mem_rdata;
    logic                 mem_we;
    logic                 mem_re;
    logic [WADDR_W-1:0]   mem_waddr;
    logic [WADDR_W-1:0]   mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;

    // control state
    pfba_state_t          state_reg, state_next;
    logic [WADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic                 done_reg, done_next;

    // configuration
    logic [ADDR_W-1:0]      frame_base_reg;
    logic [CFG_COUNT_W-1:0] frame_count_reg;
    logic [COUNT_W-1:0]     active_count;

    // captured request
    req_type_t            kind_reg;
    logic [INDEX_W-1:0]   index_in_reg;
    logic [ADDR_W-1:0]    address_reg;
    logic                 state_bit_reg;

    // working registers
    logic [FRAME_IDX_W-1:0] idx_reg, idx_next;
    logic [WADDR_W-1:0]     scan_word_reg, scan_word_next;

    // result registers
    logic                 found_reg, found_next;
    logic [ADDR_W-1:0]    free_address_reg, free_address_next;
    logic                 bit_value_reg, bit_value_next;
    logic                 in_range_reg, in_range_next;

    // decode signals
    logic [ADDR_W-1:0]              addr_off;
    logic [ADDR_W-FRAME_SHIFT-1:0]  addr_frame;
    logic                           dec_ok;
    logic [FRAME_IDX_W-1:0]         dec_idx;

    // scan signals
    logic [COUNT_W-1:0]     word_lo;
    logic [COUNT_W-1:0]     remaining;
    logic [COUNT_W-1:0]     next_lo;
    logic [WORD_BITS-1:0]   valid_mask;
    logic [WORD_BITS-1:0]   free_bits;
    logic                   scan_hit;
    logic [BIT_W-1:0]       hit_bit;
    logic [FRAME_IDX_W-1:0] hit_idx;
    logic [ADDR_W-1:0]      hit_addr;
    logic                   scan_more;

    // single-frame access signals
    logic [WADDR_W-1:0]     acc_word;
    logic [BIT_W-1:0]       acc_bit;
    logic [WORD_BITS-1:0]   wr_word;

    logic                   accept;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // clamp the frame count to the bitmap size
    always_comb
    begin
        if (32'(frame_count_reg) > 32'(MAX_FRAMES))
        begin
            active_count = COUNT_W'(MAX_FRAMES);
        end
        else
        begin
            active_count = COUNT_W'(frame_count_reg);
        end
    end

    // index and range check for the captured request
    always_comb
    begin
        addr_off   = address_reg - frame_base_reg;
        addr_frame = addr_off[ADDR_W-1:FRAME_SHIFT];
        case (kind_reg)
            REQ_SET_ADDR:
            begin
                dec_ok  = (address_reg >= frame_base_reg) &&
                          (32'(addr_frame) < 32'(active_count));
                dec_idx = FRAME_IDX_W'(addr_frame);
            end
            default:
            begin
                dec_ok  = (32'(index_in_reg) < 32'(active_count));
                dec_idx = FRAME_IDX_W'(index_in_reg);
            end
        endcase
    end

    // lowest free frame in the word just read
    always_comb
    begin
        word_lo   = COUNT_W'({scan_word_reg, {BIT_W{1'b0}}});
        remaining = active_count - word_lo;
        next_lo   = word_lo + COUNT_W'(WORD_BITS);
        scan_more = (next_lo < active_count);
        for (int b = 0; b < WORD_BITS; b++)
        begin
            valid_mask[b] = (COUNT_W'(b) < remaining);
        end
        free_bits = ~mem_rdata & valid_mask;
        scan_hit  = |free_bits;
        hit_bit   = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (free_bits[b])
            begin
                hit_bit = BIT_W'(b);
            end
        end
        hit_idx  = {scan_word_reg, hit_bit};
        hit_addr = frame_base_reg + (ADDR_W'(hit_idx) << FRAME_SHIFT);
    end

    // word and bit of a single-frame access
    always_comb
    begin
        acc_word         = idx_reg[FRAME_IDX_W-1:BIT_W];
        acc_bit          = idx_reg[BIT_W-1:0];
        wr_word          = mem_rdata;
        wr_word[acc_bit] = state_bit_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == WADDR_W'(BITMAP_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (kind_reg == REQ_FIND)
                begin
                    state_next = (active_count == '0) ? ST_IDLE : ST_SCAN_RD;
                end
                else
                begin
                    state_next = dec_ok ? ST_ACC_RD : ST_IDLE;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                state_next = (scan_hit || !scan_more) ? ST_IDLE : ST_SCAN_RD;
            end
            ST_ACC_RD:
            begin
                state_next = ST_ACC_WR;
            end
            ST_ACC_WR:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory control, working registers and results
    always_comb
    begin
        clr_addr_next     = clr_addr_reg;
        idx_next          = idx_reg;
        scan_word_next    = scan_word_reg;
        done_next         = 1'b0;
        found_next        = found_reg;
        free_address_next = free_address_reg;
        bit_value_next    = bit_value_reg;
        in_range_next     = in_range_reg;
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        mem_waddr         = acc_word;
        mem_raddr         = acc_word;
        mem_wdata         = wr_word;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            ST_DECODE:
            begin
                idx_next       = dec_idx;
                scan_word_next = '0;
                if ((kind_reg == REQ_FIND && active_count == '0) ||
                    (kind_reg != REQ_FIND && !dec_ok))
                begin
                    done_next         = 1'b1;
                    found_next        = 1'b0;
                    free_address_next = '0;
                    bit_value_next    = 1'b0;
                    in_range_next     = 1'b0;
                end
            end
            ST_SCAN_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = scan_word_reg;
            end
            ST_SCAN_CHK:
            begin
                if (scan_hit)
                begin
                    done_next         = 1'b1;
                    found_next        = 1'b1;
                    free_address_next = hit_addr;
                    bit_value_next    = 1'b0;
                    in_range_next     = 1'b1;
                end
                else if (!scan_more)
                begin
                    done_next         = 1'b1;
                    found_next        = 1'b0;
                    free_address_next = '0;
                    bit_value_next    = 1'b0;
                    in_range_next     = 1'b0;
                end
                else
                begin
                    scan_word_next = scan_word_reg + 1'b1;
                end
            end
            ST_ACC_RD:
            begin
                mem_re = 1'b1;
            end
            ST_ACC_WR:
            begin
                done_next         = 1'b1;
                found_next        = 1'b0;
                free_address_next = '0;
                in_range_next     = 1'b1;
                if (kind_reg == REQ_READ_IDX)
                begin
                    bit_value_next = mem_rdata[acc_bit];
                end
                else
                begin
                    bit_value_next = 1'b0;
                    mem_we         = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // bitmap memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bitmap_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata <= bitmap_mem[mem_raddr];
        end
    end

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            done_reg        <= 1'b0;
            frame_base_reg  <= '0;
            frame_count_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            done_reg     <= done_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_FRAME_BASE:  frame_base_reg  <= cfg_data[ADDR_W-1:0];
                    CFG_FRAME_COUNT: frame_count_reg <= cfg_data[CFG_COUNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // request capture, working and result registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg      <= req_type;
            index_in_reg  <= frame_index;
            address_reg   <= frame_address;
            state_bit_reg <= frame_state;
        end
        idx_reg          <= idx_next;
        scan_word_reg    <= scan_word_next;
        found_reg        <= found_next;
        free_address_reg <= free_address_next;
        bit_value_reg    <= bit_value_next;
        in_range_reg     <= in_range_next;
    end

    // result ports
    assign done         = done_reg;
    assign found        = found_reg;
    assign free_address = free_address_reg;
    assign bit_value    = bit_value_reg;
    assign in_range     = in_range_reg;

    // checks
    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_DECODE))
        else $error("accepted transaction did not enter decode");

    a_no_done_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !done_reg)
        else $error("result shown during clearing pass");

    a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && found_reg) |-> in_range_reg)
        else $error("found frame flagged out of range");

    a_bit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && bit_value_reg) |-> (in_range_reg && !found_reg))
        else $error("bit value reported without an in-range read");

    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_ACC_WR))
        else $error("bitmap written outside clear or write back");

endmodule
